/* src/s2h_pkg.sv */
// Shared types and constants for the serial-to-HID report bridge.
// Used by the front, queue, back and top-level modules; depends on nothing.
package s2h_pkg;

  localparam int unsigned MsgLen        = 9;
  localparam int unsigned ByteCountW    = 4;
  localparam int unsigned PayloadW      = 64;
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [7:0] MSG_MOVE     = 8'h01;
  localparam logic [7:0] MSG_BUTTON   = 8'h02;
  localparam logic [7:0] MSG_KEY      = 8'h03;
  localparam logic [7:0] MSG_MODE_SEL = 8'h04;
  localparam logic [7:0] MSG_WHEEL    = 8'h05;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic REPORT_KEYBOARD = 1'b0;
  localparam logic REPORT_MOUSE    = 1'b1;

  typedef enum logic [2:0] {
    OP_MOVE   = 3'd0,
    OP_BUTTON = 3'd1,
    OP_KEY    = 3'd2,
    OP_SWITCH = 3'd3,
    OP_WHEEL  = 3'd4,
    OP_TICK   = 3'd5
  } s2h_op_e;

  typedef struct packed {
    s2h_op_e               op;
    logic [PayloadW-1:0]   payload;
  } s2h_cmd_t;

  typedef struct packed {
    logic        report_kind;
    logic        last_report;
    logic [7:0]  button_or_modifier_bits;
    logic [47:0] key_codes;
    logic [7:0]  move_x;
    logic [7:0]  move_y;
    logic [7:0]  wheel_vertical;
    logic [7:0]  wheel_horizontal;
    logic        remote_active;
  } s2h_report_t;

endpackage

/* src/s2h_front.sv */
// Front end: gathers serial bytes into messages and classifies them into commands,
// or in tick mode turns each byte into a tick. Depends on s2h_pkg; feeds the command queue.
module s2h_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [7:0]         rx_byte_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output s2h_pkg::s2h_cmd_t  push_cmd_o
);
  import s2h_pkg::*;

  localparam logic [ByteCountW-1:0] LastIdx = ByteCountW'(MsgLen - 1);

  logic [ByteCountW-1:0] byte_count_q, byte_count_d;
  logic [7:0]            type_q, type_d;
  logic [PayloadW-1:0]   payload_q, payload_d;
  logic [PayloadW-1:0]   payload_shift;
  logic                  accept;
  logic                  type_known;
  s2h_op_e               type_op;

  assign in_ready_o    = push_ready_i;
  assign accept        = in_valid_i & in_ready_o;
  assign payload_shift = {rx_byte_i, payload_q[PayloadW-1:8]};

  always_comb begin
    type_known = 1'b1;
    type_op    = OP_MOVE;
    unique case (type_q)
      MSG_MOVE:     type_op = OP_MOVE;
      MSG_BUTTON:   type_op = OP_BUTTON;
      MSG_KEY:      type_op = OP_KEY;
      MSG_MODE_SEL: type_op = OP_SWITCH;
      MSG_WHEEL:    type_op = OP_WHEEL;
      default:      type_known = 1'b0;
    endcase
  end

  always_comb begin
    byte_count_d       = byte_count_q;
    type_d             = type_q;
    payload_d          = payload_q;
    push_valid_o       = 1'b0;
    push_cmd_o.op      = OP_TICK;
    push_cmd_o.payload = payload_shift;
    if (accept) begin
      if (mode_i == MODE_TICK) begin
        push_valid_o = 1'b1;
      end else if (byte_count_q == '0) begin
        type_d       = rx_byte_i;
        byte_count_d = ByteCountW'(1);
      end else begin
        payload_d = payload_shift;
        if (byte_count_q == LastIdx) begin
          byte_count_d  = '0;
          push_valid_o  = type_known;
          push_cmd_o.op = type_op;
        end else begin
          byte_count_d = byte_count_q + ByteCountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
    end else begin
      byte_count_q <= byte_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q    <= type_d;
    payload_q <= payload_d;
  end

endmodule

/* src/s2h_queue.sv */
// Short command queue that decouples the front end from the back end.
// Depends on s2h_pkg for the command type.
module s2h_queue #(
  parameter int unsigned Depth = s2h_pkg::QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  s2h_pkg::s2h_cmd_t  push_cmd_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output s2h_pkg::s2h_cmd_t  pop_cmd_o
);
  import s2h_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  s2h_cmd_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* src/s2h_back.sv */
// Back end: applies commands to the mouse, keyboard and mode state and builds reports.
// Depends on s2h_pkg; holds the output register of the result channel.
module s2h_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  s2h_pkg::s2h_cmd_t     cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output s2h_pkg::s2h_report_t  report_o
);
  import s2h_pkg::*;

  function automatic logic [7:0] sat8(input logic [15:0] v);
    logic [7:0] r;
    if (!v[15] && (v[14:7] != 8'h00)) begin
      r = 8'h7F;
    end else if (v[15] && (v[14:7] != 8'hFF)) begin
      r = 8'h80;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  logic [15:0] accum_x_q, accum_x_d, accum_y_q, accum_y_d;
  logic [7:0]  wheel_v_q, wheel_v_d, wheel_h_q, wheel_h_d;
  logic [7:0]  buttons_q, buttons_d;
  logic        mouse_dirty_q, mouse_dirty_d;
  logic [7:0]  mods_q, mods_d;
  logic [47:0] keys_q, keys_d;
  logic        kbd_dirty_q, kbd_dirty_d;
  logic        remote_q, remote_d;
  logic        out_valid_q, out_valid_d;
  s2h_report_t report_q, report_d;

  logic        out_free;
  logic        emit;
  logic [7:0]  sat_x, sat_y;
  logic [15:0] rem_x, rem_y;
  logic [7:0]  btn_num;
  logic [2:0]  btn_idx;

  assign out_free = !out_valid_q || out_ready_i;
  assign sat_x    = sat8(accum_x_q);
  assign sat_y    = sat8(accum_y_q);
  assign rem_x    = accum_x_q - {{8{sat_x[7]}}, sat_x};
  assign rem_y    = accum_y_q - {{8{sat_y[7]}}, sat_y};
  assign btn_num  = cmd_i.payload[7:0];
  assign btn_idx  = 3'(btn_num - 8'd1);

  always_comb begin
    accum_x_d     = accum_x_q;
    accum_y_d     = accum_y_q;
    wheel_v_d     = wheel_v_q;
    wheel_h_d     = wheel_h_q;
    buttons_d     = buttons_q;
    mouse_dirty_d = mouse_dirty_q;
    mods_d        = mods_q;
    keys_d        = keys_q;
    kbd_dirty_d   = kbd_dirty_q;
    remote_d      = remote_q;
    cmd_ready_o   = 1'b0;
    emit          = 1'b0;
    report_d      = '0;
    report_d.remote_active = remote_q;
    if (cmd_valid_i) begin
      unique case (cmd_i.op)
        OP_MOVE: begin
          accum_x_d     = accum_x_q + cmd_i.payload[15:0];
          accum_y_d     = accum_y_q + cmd_i.payload[31:16];
          mouse_dirty_d = 1'b1;
          cmd_ready_o   = 1'b1;
        end
        OP_BUTTON: begin
          if ((btn_num >= 8'd1) && (btn_num <= 8'd8)) begin
            buttons_d[btn_idx] = (cmd_i.payload[15:8] != 8'h00);
          end
          mouse_dirty_d = 1'b1;
          cmd_ready_o   = 1'b1;
        end
        OP_KEY: begin
          mods_d      = cmd_i.payload[7:0];
          keys_d      = cmd_i.payload[63:16];
          kbd_dirty_d = 1'b1;
          cmd_ready_o = 1'b1;
        end
        OP_SWITCH: begin
          remote_d      = (cmd_i.payload[7:0] == 8'd1);
          accum_x_d     = '0;
          accum_y_d     = '0;
          wheel_v_d     = '0;
          wheel_h_d     = '0;
          mouse_dirty_d = 1'b0;
          cmd_ready_o   = 1'b1;
        end
        OP_WHEEL: begin
          wheel_v_d     = wheel_v_q + cmd_i.payload[7:0];
          wheel_h_d     = wheel_h_q + cmd_i.payload[23:16];
          mouse_dirty_d = 1'b1;
          cmd_ready_o   = 1'b1;
        end
        OP_TICK: begin
          if (out_free) begin
            if (kbd_dirty_q) begin
              emit                             = 1'b1;
              report_d.report_kind             = REPORT_KEYBOARD;
              report_d.last_report             = !mouse_dirty_q;
              report_d.button_or_modifier_bits = mods_q;
              report_d.key_codes               = keys_q;
              kbd_dirty_d                      = 1'b0;
              cmd_ready_o                      = !mouse_dirty_q;
            end else if (mouse_dirty_q) begin
              emit                             = 1'b1;
              report_d.report_kind             = REPORT_MOUSE;
              report_d.last_report             = 1'b1;
              report_d.button_or_modifier_bits = buttons_q;
              report_d.move_x                  = sat_x;
              report_d.move_y                  = sat_y;
              report_d.wheel_vertical          = wheel_v_q;
              report_d.wheel_horizontal        = wheel_h_q;
              accum_x_d                        = rem_x;
              accum_y_d                        = rem_y;
              wheel_v_d                        = '0;
              wheel_h_d                        = '0;
              mouse_dirty_d = remote_q && ((rem_x != 16'h0000) || (rem_y != 16'h0000));
              cmd_ready_o                      = 1'b1;
            end else begin
              cmd_ready_o = 1'b1;
            end
          end
        end
        default: cmd_ready_o = 1'b1;
      endcase
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_x_q     <= '0;
      accum_y_q     <= '0;
      wheel_v_q     <= '0;
      wheel_h_q     <= '0;
      buttons_q     <= '0;
      mouse_dirty_q <= 1'b0;
      mods_q        <= '0;
      keys_q        <= '0;
      kbd_dirty_q   <= 1'b0;
      remote_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      accum_x_q     <= accum_x_d;
      accum_y_q     <= accum_y_d;
      wheel_v_q     <= wheel_v_d;
      wheel_h_q     <= wheel_h_d;
      buttons_q     <= buttons_d;
      mouse_dirty_q <= mouse_dirty_d;
      mods_q        <= mods_d;
      keys_q        <= keys_d;
      kbd_dirty_q   <= kbd_dirty_d;
      remote_q      <= remote_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      report_q <= report_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign report_o    = report_q;

endmodule

/* src/serial_to_hid_report_bridge.sv */
// Serial-to-HID report bridge: 9-byte serial messages update mouse and keyboard state,
// and each send-slot tick emits a keyboard report and/or a mouse report for whichever state is dirty.
// Throughput: one input item per cycle while the command queue has room; a tick that yields two
// reports holds the back end until both are emitted, and the command queue absorbs items meanwhile.
// Each report is registered: the back end writes it into the output register while serving the tick.
// Reset (asynchronous, active low) clears back-end state, byte count, queue pointers and output valid.
module serial_to_hid_report_bridge #(
  parameter int unsigned QueueDepth = s2h_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        report_kind_o,
  output logic        last_report_o,
  output logic [7:0]  button_or_modifier_bits_o,
  output logic [47:0] key_codes_o,
  output logic [7:0]  move_x_o,
  output logic [7:0]  move_y_o,
  output logic [7:0]  wheel_vertical_o,
  output logic [7:0]  wheel_horizontal_o,
  output logic        remote_active_o
);
  import s2h_pkg::*;

  logic        push_valid, push_ready;
  s2h_cmd_t    push_cmd;
  logic        pop_valid, pop_ready;
  s2h_cmd_t    pop_cmd;
  s2h_report_t report;

  s2h_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .rx_byte_i    (rx_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  s2h_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  s2h_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .report_o    (report)
  );

  assign report_kind_o             = report.report_kind;
  assign last_report_o             = report.last_report;
  assign button_or_modifier_bits_o = report.button_or_modifier_bits;
  assign key_codes_o               = report.key_codes;
  assign move_x_o                  = report.move_x;
  assign move_y_o                  = report.move_y;
  assign wheel_vertical_o          = report.wheel_vertical;
  assign wheel_horizontal_o        = report.wheel_horizontal;
  assign remote_active_o           = report.remote_active;

  a_mouse_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (report_kind_o == REPORT_MOUSE)) |-> last_report_o)
    else $error("Mouse report not marked as last.");

  a_mouse_no_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (report_kind_o == REPORT_MOUSE)) |-> (key_codes_o == 48'h0))
    else $error("Mouse report carries key codes.");

  a_kbd_then_mouse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && (report_kind_o == REPORT_KEYBOARD) && !last_report_o)
    |=> (out_valid_o && (report_kind_o == REPORT_MOUSE)))
    else $error("Keyboard report not followed by mouse report.");

endmodule
